### rtl/core/tlpq_pkg.sv
// Shared constants, codes and types for the three-level priority queue.
package tlpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int MODE_W = 2;
    localparam int ID_W   = 32;
    localparam int LVL_W  = 2;
    localparam int ORD_W  = 16;
    localparam int ST_W   = 2;
    localparam int ERR_W  = 3;

    localparam int CMD_W   = MODE_W + ID_W + LVL_W + ORD_W + ST_W;
    localparam int RES_W   = ERR_W + ID_W + LVL_W + ORD_W + ST_W;
    localparam int S_DATA_W = ((CMD_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // command codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START  = 2'd2;

    // result codes
    localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_PRI   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY     = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NOT_FOUND = 3'd3;
    localparam logic [ERR_W-1:0] ERR_FULL      = 3'd4;

    // register index of the in-exam status code
    localparam logic REG_IN_EXAM = 1'b0;
    localparam logic [ST_W-1:0] IN_EXAM_RESET = 2'd1;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ORD_W-1:0]  reg_order;
        logic [LVL_W-1:0]  priority_req;
        logic [ID_W-1:0]   patient_id;
        logic [MODE_W-1:0] mode;
    } cmd_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ORD_W-1:0] order;
        logic [LVL_W-1:0] level;
        logic [ID_W-1:0]  id;
    } entry_t;

    typedef struct packed {
        logic [ST_W-1:0]  out_status;
        logic [ORD_W-1:0] out_order;
        logic [LVL_W-1:0] out_priority;
        logic [ID_W-1:0]  out_id;
        logic [ERR_W-1:0] error_code;
    } res_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
    } tbl_wr_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] fill;
    } seq_stat_t;

endpackage

### rtl/core/tlpq_cmp.sv
// Shared compare unit: priority compare for pop, id match for start.
module tlpq_cmp import tlpq_pkg::*; (
    input  logic             is_pop,
    input  logic             first,
    input  entry_t           cur,
    input  logic [LVL_W-1:0] best_lvl,
    input  logic [ID_W-1:0]  key,
    output logic             take
);

    logic lvl_lt;
    logic id_eq;

    assign lvl_lt = cur.level < best_lvl;
    assign id_eq  = cur.id == key;
    // first entry always seeds the best; later ones win only on strictly better level
    assign take   = is_pop ? (first || lvl_lt) : id_eq;

endmodule

### rtl/core/tlpq_table.sv
// Record table: one write port, one read port, registered read data.
module tlpq_table import tlpq_pkg::*; (
    input  logic             aclk,
    input  tbl_wr_t          wr,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [QUEUE_DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.waddr] <= wr.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/tlpq_seq.sv
// Command sequencer: scans the table through the shared compare unit and shifts on pop.
module tlpq_seq import tlpq_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  cmd_t            s_cmd,
    input  logic [ST_W-1:0] exam_code,
    input  logic            out_free,
    output logic            ready,
    output logic            res_vld,
    output res_t            res,
    output tbl_wr_t         tbl_wr,
    output logic [IDX_W-1:0] tbl_raddr,
    input  entry_t          tbl_rdata,
    output seq_stat_t       stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SH_RD = 3'd2;
    localparam logic [2:0] S_SH_WR = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg,   state_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;
    logic [CNT_W-1:0] rd_idx_reg,  rd_idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [LVL_W-1:0] best_lvl_reg, best_lvl_next;
    entry_t           best_data_reg, best_data_next;
    logic [IDX_W-1:0] sh_idx_reg,  sh_idx_next;
    cmd_t             cmd_reg,     cmd_next;
    res_t             res_reg,     res_next;

    logic             take;
    logic             is_pop;
    logic             last;
    logic [CNT_W-1:0] sh_succ;
    entry_t           pick;
    entry_t           marked;

    assign is_pop  = cmd_reg.mode == MODE_POP;
    assign last    = (CNT_W'(chk_idx_reg) + 1'b1) == cnt_reg;
    assign sh_succ = CNT_W'(sh_idx_reg) + 1'b1;
    assign pick    = take ? tbl_rdata : best_data_reg;

    always_comb begin
        marked        = tbl_rdata;
        marked.status = exam_code;
    end

    tlpq_cmp u_cmp (
        .is_pop   (is_pop),
        .first    (chk_idx_reg == '0),
        .cur      (tbl_rdata),
        .best_lvl (best_lvl_reg),
        .key      (cmd_reg.patient_id),
        .take     (take)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_idx_next    = rd_idx_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        best_idx_next  = best_idx_reg;
        best_lvl_next  = best_lvl_reg;
        best_data_next = best_data_reg;
        sh_idx_next    = sh_idx_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        tbl_wr         = '0;
        tbl_raddr      = rd_idx_reg[IDX_W-1:0];
        res_vld        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    res_next   = '0;
                    state_next = S_DONE;
                    case (s_cmd.mode)
                        MODE_INSERT: begin
                            if (s_cmd.priority_req == '0) begin
                                res_next.error_code = ERR_BAD_PRI;
                            end else if (cnt_reg == CNT_W'(QUEUE_DEPTH)) begin
                                res_next.error_code = ERR_FULL;
                            end else begin
                                tbl_wr.we           = 1'b1;
                                tbl_wr.waddr        = cnt_reg[IDX_W-1:0];
                                tbl_wr.wdata.id     = s_cmd.patient_id;
                                tbl_wr.wdata.level  = s_cmd.priority_req;
                                tbl_wr.wdata.order  = s_cmd.reg_order;
                                tbl_wr.wdata.status = s_cmd.status;
                                cnt_next            = cnt_reg + 1'b1;
                            end
                        end
                        MODE_POP: begin
                            if (cnt_reg == '0) begin
                                res_next.error_code = ERR_EMPTY;
                            end else begin
                                rd_idx_next = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        MODE_START: begin
                            if (cnt_reg == '0) begin
                                res_next.error_code = ERR_NOT_FOUND;
                            end else begin
                                rd_idx_next = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        default: begin
                            // unused code: all-zero result
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (rd_idx_reg < cnt_reg) begin
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_idx_reg[IDX_W-1:0];
                end
                if (chk_vld_reg) begin
                    if (is_pop) begin
                        if (take) begin
                            best_idx_next  = chk_idx_reg;
                            best_lvl_next  = tbl_rdata.level;
                            best_data_next = tbl_rdata;
                        end
                        if (last) begin
                            sh_idx_next           = take ? chk_idx_reg : best_idx_reg;
                            res_next.error_code   = ERR_OK;
                            res_next.out_id       = pick.id;
                            res_next.out_priority = pick.level;
                            res_next.out_order    = pick.order;
                            res_next.out_status   = pick.status;
                            state_next            = S_SH_RD;
                        end
                    end else begin
                        if (take) begin
                            tbl_wr.we    = 1'b1;
                            tbl_wr.waddr = chk_idx_reg;
                            tbl_wr.wdata = marked;
                            state_next   = S_DONE;
                        end else if (last) begin
                            res_next.error_code = ERR_NOT_FOUND;
                            state_next          = S_DONE;
                        end
                    end
                end
            end

            S_SH_RD: begin
                if (sh_succ < cnt_reg) begin
                    tbl_raddr  = sh_succ[IDX_W-1:0];
                    state_next = S_SH_WR;
                end else begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_SH_WR: begin
                tbl_wr.we    = 1'b1;
                tbl_wr.waddr = sh_idx_reg;
                tbl_wr.wdata = tbl_rdata;
                sh_idx_next  = sh_idx_reg + 1'b1;
                state_next   = S_SH_RD;
            end

            S_DONE: begin
                if (out_free) begin
                    res_vld    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        chk_idx_reg   <= chk_idx_next;
        best_idx_reg  <= best_idx_next;
        best_lvl_reg  <= best_lvl_next;
        best_data_reg <= best_data_next;
        sh_idx_reg    <= sh_idx_next;
        cmd_reg       <= cmd_next;
        res_reg       <= res_next;
    end

    assign ready     = state_reg == S_IDLE;
    assign res       = res_reg;
    assign stat.busy = state_reg != S_IDLE;
    assign stat.fill = cnt_reg;

endmodule

### rtl/core/three_level_priority_queue_core.sv
// Top level: stream ports, APB register, sequencer, record table and output register.
// Insert, bad priority, empty pop, unused mode and start on an empty queue go to the output
// register without a table scan; start scans the records, pop scans them and shifts the later ones down.
// Throughput: one beat at a time; the next beat is taken once the previous result has left the sequencer.
// Reset (aresetn low at a clock edge): empties the queue, clears both valids, in_exam_code = 1.
module three_level_priority_queue_core import tlpq_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    // command beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [1:0] mode, [33:2] patient_id, [35:34] priority_req, [51:36] reg_order,
    // [53:52] status, [55:54] zero
    input  logic [S_DATA_W-1:0]   s_tdata,

    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] error_code, [34:3] out_id, [36:35] out_priority, [52:37] out_order,
    // [54:53] out_status, [55] zero
    output logic [M_DATA_W-1:0]   m_tdata,

    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // in-exam status code register, byte address 0
    logic [ST_W-1:0] exam_code_reg, exam_code_next;
    logic            cfg_wr;
    logic            reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2] == REG_IN_EXAM;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        exam_code_next = exam_code_reg;
        if (cfg_wr && reg_sel) begin
            exam_code_next = pwdata[ST_W-1:0];
        end
    end

    assign prdata = reg_sel ? APB_DATA_W'(exam_code_reg) : '0;

    // sequencer and table
    logic             seq_ready;
    logic             res_vld;
    res_t             res;
    tbl_wr_t          tbl_wr;
    logic [IDX_W-1:0] tbl_raddr;
    entry_t           tbl_rdata;
    seq_stat_t        stat;
    logic             out_free;

    tlpq_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_cmd     (cmd_t'(s_tdata[CMD_W-1:0])),
        .exam_code (exam_code_reg),
        .out_free  (out_free),
        .ready     (seq_ready),
        .res_vld   (res_vld),
        .res       (res),
        .tbl_wr    (tbl_wr),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata),
        .stat      (stat)
    );

    tlpq_table u_table (
        .aclk  (aclk),
        .wr    (tbl_wr),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign s_tready = seq_ready;

    // output register: holds a finished result while the sequencer takes the next beat
    logic          out_vld_reg, out_vld_next;
    res_t          out_res_reg, out_res_next;

    assign out_free = !out_vld_reg || m_tready;

    always_comb begin
        out_vld_next = out_vld_reg;
        out_res_next = out_res_reg;
        if (res_vld) begin
            out_vld_next = 1'b1;
            out_res_next = res;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exam_code_reg <= IN_EXAM_RESET;
            out_vld_reg   <= 1'b0;
        end else begin
            exam_code_reg <= exam_code_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_DATA_W'(out_res_reg);

    // checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.fill <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count above queue depth");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && stat.busy)
        else $error("command taken without sequencer going busy");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (stat.fill != $past(stat.fill)) |->
            (stat.fill == $past(stat.fill) + 1'b1) || (stat.fill + 1'b1 == $past(stat.fill)))
        else $error("fill count moved by more than one");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        res_vld |-> res.error_code <= ERR_FULL)
        else $error("undefined result code");

endmodule
